/* sv/buffer_pool_lfu_lookup_assert.svh */
// ----------------------------------------------------------------------------
// Buffer pool LFU lookup - assertion macros
// Shared concurrent assertion forms used by the RTL of the lookup block.
// ----------------------------------------------------------------------------
`ifndef BUFFER_POOL_LFU_LOOKUP_ASSERT_SVH
`define BUFFER_POOL_LFU_LOOKUP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define BLP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BLP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/blp_pkg.sv */
// ----------------------------------------------------------------------------
// Buffer pool LFU lookup - package
// Field widths, operation codes and the slot entry / result word types.
// ----------------------------------------------------------------------------
package blp_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int FILE_W   = 8;
    localparam int BLOCK_W  = 24;
    localparam int COUNT_W  = 16;
    localparam int SLOT_W   = 4;

    localparam int IN_TDATA_W  = 40;  // file, block, modify, padding
    localparam int OUT_TDATA_W = 40;  // slot, wb file, wb block, padding
    localparam int OUT_TUSER_W = 2;   // hit, writeback valid

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // operation codes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // one slot as held in the entry memory
    typedef struct packed {
        logic [FILE_W-1:0]  file;
        logic [BLOCK_W-1:0] block;
        logic [COUNT_W-1:0] count;
        logic               dirty;
    } blp_entry_t;

    // one result word
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic               wb_valid;
        logic [FILE_W-1:0]  wb_file;
        logic [BLOCK_W-1:0] wb_block;
        logic               last;
    } blp_result_t;

endpackage

/* sv/buffer_pool_lfu_lookup.sv */
// An access gives a single result word; a flush gives one word per dirty slot
// (one empty word if none is dirty), and the master side can stall either.
// The scan reads one slot a cycle, unless a flush word is held, through the entry
// memory read port (one read, one write port); requests are taken only when idle.
// Reset (aresetn low, synchronous): slot valid bits and control state clear at
// once; the entry memory is not swept, an invalid slot counts as empty.
// ----------------------------------------------------------------------------
// Buffer pool LFU lookup - top level
// Fully associative slot table with least-frequently-used replacement.
// ----------------------------------------------------------------------------
module buffer_pool_lfu_lookup
    import blp_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // file_id, block_index, will_modify
    input  logic [0:0]             s_tuser,   // op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // slot, writeback_file, writeback_block
    output logic [OUT_TUSER_W-1:0] m_tuser,   // hit, writeback_valid
    output logic                   m_tlast    // last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    blp_entry_t         ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    blp_entry_t         ram_rdata;
    logic               res_valid;
    blp_result_t        res;
    logic               out_free;

    // request word unpacking
    logic [FILE_W-1:0]  in_file;
    logic [BLOCK_W-1:0] in_block;
    logic               in_modify;

    assign in_file   = s_tdata[FILE_W-1:0];
    assign in_block  = s_tdata[FILE_W+BLOCK_W-1:FILE_W];
    assign in_modify = s_tdata[FILE_W+BLOCK_W];

    blp_entry_ram #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    blp_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_op      (s_tuser[0]),
        .s_file    (in_file),
        .s_block   (in_block),
        .s_modify  (in_modify),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free)
    );

    blp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* sv/blp_entry_ram.sv */
// ----------------------------------------------------------------------------
// Buffer pool LFU lookup - slot entry memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module blp_entry_ram
    import blp_pkg::*;
#(
    parameter int DEPTH  = NUM_SLOTS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  blp_entry_t        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output blp_entry_t        rdata
);

    blp_entry_t mem [DEPTH];
    blp_entry_t rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/blp_ctrl.sv */
// ----------------------------------------------------------------------------
// Buffer pool LFU lookup - scan sequencer
// Walks the entry memory one slot per cycle: tag match and LFU victim search
// on an access, dirty write-back and mark clearing on a flush (output may stall).
// ----------------------------------------------------------------------------
`include "buffer_pool_lfu_lookup_assert.svh"

module blp_ctrl
    import blp_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    // request side
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [FILE_W-1:0]  s_file,
    input  logic [BLOCK_W-1:0] s_block,
    input  logic               s_modify,
    // entry memory
    output logic               ram_we,
    output logic [IDX_W-1:0]   ram_waddr,
    output blp_entry_t         ram_wdata,
    output logic               ram_re,
    output logic [IDX_W-1:0]   ram_raddr,
    input  blp_entry_t         ram_rdata,
    // result side
    output logic               res_valid,
    output blp_result_t        res,
    input  logic               out_free
);

    localparam int PTR_W = $clog2(NUM_SLOTS + 1);
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(NUM_SLOTS);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_ACC_FIN = 2'd2;
    localparam logic [1:0] ST_FL_FIN  = 2'd3;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, idx};
        return w[SLOT_W-1:0];
    endfunction

    logic [1:0]           state_reg,      state_next;
    logic                 op_reg,         op_next;
    logic [FILE_W-1:0]    file_reg,       file_next;
    logic [BLOCK_W-1:0]   block_reg,      block_next;
    logic                 modify_reg,     modify_next;
    logic [PTR_W-1:0]     rd_ptr_reg,     rd_ptr_next;
    logic                 chk_v_reg,      chk_v_next;
    logic [IDX_W-1:0]     chk_idx_reg,    chk_idx_next;
    logic [NUM_SLOTS-1:0] valid_reg,      valid_next;
    logic                 hit_reg,        hit_next;
    logic [IDX_W-1:0]     hit_idx_reg,    hit_idx_next;
    blp_entry_t           hit_entry_reg,  hit_entry_next;
    logic [IDX_W-1:0]     vic_idx_reg,    vic_idx_next;
    logic [COUNT_W-1:0]   vic_cnt_reg,    vic_cnt_next;
    logic                 vic_valid_reg,  vic_valid_next;
    blp_entry_t           vic_entry_reg,  vic_entry_next;
    logic                 pend_v_reg,     pend_v_next;
    logic [IDX_W-1:0]     pend_idx_reg,   pend_idx_next;
    logic [FILE_W-1:0]    pend_file_reg,  pend_file_next;
    logic [BLOCK_W-1:0]   pend_block_reg, pend_block_next;

    logic               scan_done;
    logic               cur_valid;
    logic               cur_match;
    logic [COUNT_W-1:0] cur_cnt;
    logic               cur_flush;
    logic               stall;
    logic               consume;
    blp_entry_t         clean_entry;

    // check stage decode on the word just read
    always_comb begin
        scan_done   = (rd_ptr_reg == PTR_END);
        cur_valid   = valid_reg[chk_idx_reg];
        cur_match   = cur_valid && (ram_rdata.file == file_reg)
                      && (ram_rdata.block == block_reg);
        cur_cnt     = cur_valid ? ram_rdata.count : '0;
        cur_flush   = (op_reg == OP_FLUSH) && cur_valid && ram_rdata.dirty;
        stall       = (state_reg == ST_SCAN) && chk_v_reg && cur_flush
                      && pend_v_reg && !out_free;
        consume     = (state_reg == ST_SCAN) && chk_v_reg && !stall;
        ram_re      = (state_reg == ST_SCAN) && !scan_done && (!chk_v_reg || consume);
        ram_raddr   = rd_ptr_reg[IDX_W-1:0];
        clean_entry = ram_rdata;
        clean_entry.dirty = 1'b0;
    end

    assign s_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        file_next       = file_reg;
        block_next      = block_reg;
        modify_next     = modify_reg;
        rd_ptr_next     = rd_ptr_reg;
        chk_v_next      = chk_v_reg;
        chk_idx_next    = chk_idx_reg;
        valid_next      = valid_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_entry_next  = hit_entry_reg;
        vic_idx_next    = vic_idx_reg;
        vic_cnt_next    = vic_cnt_reg;
        vic_valid_next  = vic_valid_reg;
        vic_entry_next  = vic_entry_reg;
        pend_v_next     = pend_v_reg;
        pend_idx_next   = pend_idx_reg;
        pend_file_next  = pend_file_reg;
        pend_block_next = pend_block_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_idx_reg;
        ram_wdata       = clean_entry;
        res_valid       = 1'b0;
        res             = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_op;
                    file_next   = s_file;
                    block_next  = s_block;
                    modify_next = s_modify;
                    rd_ptr_next = '0;
                    chk_v_next  = 1'b0;
                    hit_next    = 1'b0;
                    pend_v_next = 1'b0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // read pointer runs one slot ahead of the check stage
                if (ram_re) begin
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                    chk_idx_next = rd_ptr_reg[IDX_W-1:0];
                end
                chk_v_next = ram_re || (chk_v_reg && !consume);

                if (consume && (op_reg == OP_ACCESS)) begin
                    if (cur_match && !hit_reg) begin
                        hit_next       = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                        hit_entry_next = ram_rdata;
                    end
                    // strict less-than keeps the lowest index on ties
                    if ((chk_idx_reg == '0) || (cur_cnt < vic_cnt_reg)) begin
                        vic_idx_next   = chk_idx_reg;
                        vic_cnt_next   = cur_cnt;
                        vic_valid_next = cur_valid;
                        vic_entry_next = ram_rdata;
                    end
                end

                if (consume && cur_flush) begin
                    // clear the mark; the previous dirty slot goes out as not last
                    ram_we    = 1'b1;
                    ram_waddr = chk_idx_reg;
                    ram_wdata = clean_entry;
                    if (pend_v_reg) begin
                        res_valid    = 1'b1;
                        res.slot     = to_slot(pend_idx_reg);
                        res.wb_valid = 1'b1;
                        res.wb_file  = pend_file_reg;
                        res.wb_block = pend_block_reg;
                    end
                    pend_v_next     = 1'b1;
                    pend_idx_next   = chk_idx_reg;
                    pend_file_next  = ram_rdata.file;
                    pend_block_next = ram_rdata.block;
                end

                if (scan_done && (!chk_v_reg || consume)) begin
                    state_next = (op_reg == OP_FLUSH) ? ST_FL_FIN : ST_ACC_FIN;
                end
            end

            ST_ACC_FIN: begin
                if (out_free) begin
                    res_valid = 1'b1;
                    res.last  = 1'b1;
                    ram_we    = 1'b1;
                    if (hit_reg) begin
                        ram_waddr       = hit_idx_reg;
                        ram_wdata       = hit_entry_reg;
                        ram_wdata.count = (hit_entry_reg.count == COUNT_MAX)
                                          ? hit_entry_reg.count
                                          : hit_entry_reg.count + 1'b1;
                        ram_wdata.dirty = hit_entry_reg.dirty | modify_reg;
                        res.slot        = to_slot(hit_idx_reg);
                        res.hit         = 1'b1;
                    end else begin
                        ram_waddr       = vic_idx_reg;
                        ram_wdata.file  = file_reg;
                        ram_wdata.block = block_reg;
                        ram_wdata.count = COUNT_W'(1);
                        ram_wdata.dirty = modify_reg;
                        valid_next[vic_idx_reg] = 1'b1;
                        res.slot        = to_slot(vic_idx_reg);
                        if (vic_valid_reg && vic_entry_reg.dirty) begin
                            res.wb_valid = 1'b1;
                            res.wb_file  = vic_entry_reg.file;
                            res.wb_block = vic_entry_reg.block;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_FL_FIN: begin
                // final dirty slot, or an empty word when nothing was dirty
                if (out_free) begin
                    res_valid = 1'b1;
                    res.last  = 1'b1;
                    if (pend_v_reg) begin
                        res.slot     = to_slot(pend_idx_reg);
                        res.wb_valid = 1'b1;
                        res.wb_file  = pend_file_reg;
                        res.wb_block = pend_block_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_ptr_reg <= '0;
            chk_v_reg  <= 1'b0;
            valid_reg  <= '0;
            hit_reg    <= 1'b0;
            pend_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            chk_v_reg  <= chk_v_next;
            valid_reg  <= valid_next;
            hit_reg    <= hit_next;
            pend_v_reg <= pend_v_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        file_reg       <= file_next;
        block_reg      <= block_next;
        modify_reg     <= modify_next;
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_entry_reg  <= hit_entry_next;
        vic_idx_reg    <= vic_idx_next;
        vic_cnt_reg    <= vic_cnt_next;
        vic_valid_reg  <= vic_valid_next;
        vic_entry_reg  <= vic_entry_next;
        pend_idx_reg   <= pend_idx_next;
        pend_file_reg  <= pend_file_next;
        pend_block_reg <= pend_block_next;
    end

    // checks
    `BLP_ASSERT_IMP(a_idle_no_mem, aclk, aresetn, state_reg == ST_IDLE, !ram_re && !ram_we, "memory accessed while idle")
    `BLP_ASSERT_NXT(a_stall_holds, aclk, aresetn, stall, chk_v_reg && $stable(chk_idx_reg), "stalled check word lost")
    `BLP_ASSERT_IMP(a_res_free, aclk, aresetn, res_valid, out_free, "result issued into a full output stage")
    `BLP_ASSERT_IMP(a_rw_apart, aclk, aresetn, ram_we && ram_re, ram_waddr != ram_raddr, "read and write collide on one slot")

endmodule

/* sv/blp_out_reg.sv */
// ----------------------------------------------------------------------------
// Buffer pool LFU lookup - result output stage
// Holds one result word for the master side and packs it onto the bus.
// ----------------------------------------------------------------------------
module blp_out_reg
    import blp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   res_valid,
    input  blp_result_t            res,
    output logic                   out_free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [OUT_TUSER_W-1:0] m_tuser,
    output logic                   m_tlast
);

    localparam int PAD_W = OUT_TDATA_W - SLOT_W - FILE_W - BLOCK_W;

    logic        m_valid_reg;
    blp_result_t res_reg;

    assign out_free = !m_valid_reg || m_tready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
    end

    // word held until taken
    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, res_reg.wb_block, res_reg.wb_file, res_reg.slot};
    assign m_tuser  = {res_reg.wb_valid, res_reg.hit};
    assign m_tlast  = res_reg.last;

endmodule

/* tb/sv/blp_pool_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool LFU lookup - stream checker
// Watches both stream channels of the lookup block. Every accepted request
// word is run through a private model of the slot table, and the words it
// should cause are queued. Every accepted result word is compared field by
// field with the oldest queued word.
// ----------------------------------------------------------------------------
module blp_pool_checker
    import blp_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // file_id, block_index, will_modify
    input  logic [0:0]             s_tuser,   // op
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // slot, writeback_file, writeback_block
    input  logic [OUT_TUSER_W-1:0] m_tuser,   // hit, writeback_valid
    input  logic                   m_tlast,   // last
    output int                     fail_count,
    output int                     words_due
);

    // model copy of the slot table
    logic               pool_valid [NUM_SLOTS];
    logic [FILE_W-1:0]  pool_file  [NUM_SLOTS];
    logic [BLOCK_W-1:0] pool_block [NUM_SLOTS];
    logic [COUNT_W-1:0] pool_count [NUM_SLOTS];
    logic               pool_dirty [NUM_SLOTS];

    // result words still owed by the block, oldest first
    blp_result_t due_results [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 40)
            $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic clear_pool();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            pool_valid[i] = 1'b0;
            pool_file[i]  = '0;
            pool_block[i] = '0;
            pool_count[i] = '0;
            pool_dirty[i] = 1'b0;
        end
        due_results.delete();
    endtask

    // Apply one request to the model table and queue the words it causes
    task automatic lookup_and_replace(input logic op, input logic [FILE_W-1:0] fid,
                                      input logic [BLOCK_W-1:0] blk, input logic wm);
        blp_result_t        w;
        int                 ndirty;
        int                 seen;
        int                 hit_slot;
        int                 victim;
        logic [COUNT_W-1:0] best;
        logic [COUNT_W-1:0] c;
        ndirty   = 0;
        seen     = 0;
        hit_slot = -1;
        victim   = 0;
        if (op == OP_FLUSH) begin
            for (int i = 0; i < NUM_SLOTS; i++)
                if (pool_valid[i] && pool_dirty[i]) ndirty++;
            if (ndirty == 0) begin
                // nothing dirty: one empty closing word
                w      = '0;
                w.last = 1'b1;
                due_results.push_back(w);
            end else begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (pool_valid[i] && pool_dirty[i]) begin
                        seen++;
                        w          = '0;
                        w.slot     = SLOT_W'(i);
                        w.wb_valid = 1'b1;
                        w.wb_file  = pool_file[i];
                        w.wb_block = pool_block[i];
                        w.last     = (seen == ndirty);
                        pool_dirty[i] = 1'b0;
                        due_results.push_back(w);
                    end
                end
            end
        end else begin
            for (int i = 0; i < NUM_SLOTS; i++)
                if (hit_slot < 0 && pool_valid[i] && pool_file[i] == fid
                    && pool_block[i] == blk)
                    hit_slot = i;
            w      = '0;
            w.last = 1'b1;
            if (hit_slot >= 0) begin
                // hit: count saturates, modify sets the dirty mark
                if (pool_count[hit_slot] != COUNT_MAX)
                    pool_count[hit_slot] = pool_count[hit_slot] + 1'b1;
                if (wm) pool_dirty[hit_slot] = 1'b1;
                w.slot = SLOT_W'(hit_slot);
                w.hit  = 1'b1;
            end else begin
                // miss: least count wins, invalid counts as zero, lowest index on ties
                best = pool_valid[0] ? pool_count[0] : '0;
                for (int i = 1; i < NUM_SLOTS; i++) begin
                    c = pool_valid[i] ? pool_count[i] : '0;
                    if (c < best) begin
                        best   = c;
                        victim = i;
                    end
                end
                w.slot = SLOT_W'(victim);
                if (pool_valid[victim] && pool_dirty[victim]) begin
                    w.wb_valid = 1'b1;
                    w.wb_file  = pool_file[victim];
                    w.wb_block = pool_block[victim];
                end
                pool_valid[victim] = 1'b1;
                pool_file[victim]  = fid;
                pool_block[victim] = blk;
                pool_count[victim] = COUNT_W'(1);
                pool_dirty[victim] = wm;
            end
            due_results.push_back(w);
        end
    endtask

    // Compare one accepted result word with the oldest one owed
    task automatic check_result();
        blp_result_t want;
        blp_result_t got;
        got.slot     = m_tdata[SLOT_W-1:0];
        got.wb_file  = m_tdata[SLOT_W +: FILE_W];
        got.wb_block = m_tdata[SLOT_W+FILE_W +: BLOCK_W];
        got.hit      = m_tuser[0];
        got.wb_valid = m_tuser[1];
        got.last     = m_tlast;
        if (due_results.size() == 0) begin
            report_mismatch("unexpected word (slot)", 32'(got.slot), 32'(0));
        end else begin
            want = due_results.pop_front();
            if (got.slot !== want.slot)
                report_mismatch("slot", 32'(got.slot), 32'(want.slot));
            if (got.hit !== want.hit)
                report_mismatch("hit", 32'(got.hit), 32'(want.hit));
            if (got.wb_valid !== want.wb_valid)
                report_mismatch("writeback_valid", 32'(got.wb_valid), 32'(want.wb_valid));
            if (got.wb_file !== want.wb_file)
                report_mismatch("writeback_file", 32'(got.wb_file), 32'(want.wb_file));
            if (got.wb_block !== want.wb_block)
                report_mismatch("writeback_block", 32'(got.wb_block), 32'(want.wb_block));
            if (got.last !== want.last)
                report_mismatch("last", 32'(got.last), 32'(want.last));
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_pool();
        end else begin
            if (s_tvalid && s_tready)
                lookup_and_replace(s_tuser[0], s_tdata[FILE_W-1:0],
                                   s_tdata[FILE_W +: BLOCK_W], s_tdata[FILE_W+BLOCK_W]);
            if (m_tvalid && m_tready)
                check_result();
        end
        words_due <= due_results.size();
    end

endmodule

/* tb/sv/tb_buffer_pool_lfu_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool LFU lookup - testbench top
// Drives request words into the lookup block in random bursts, stalls the
// result side on its own pattern (with one long hold-off), and leaves the
// prediction and comparison to the stream checker beside the block.
// ----------------------------------------------------------------------------
module tb_buffer_pool_lfu_lookup;
    import blp_pkg::*;

    localparam int NSLOTS   = NUM_SLOTS_DEF;
    localparam int RAND_N   = 450;
    localparam int TAG_POOL = 24;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;
    int                     fail_count;
    int                     words_due;

    // sender burst state
    int                     burst_left;

    logic [FILE_W-1:0]      pool_fid [TAG_POOL];
    logic [BLOCK_W-1:0]     pool_blk [TAG_POOL];

    always #10 aclk = ~aclk;

    buffer_pool_lfu_lookup #(
        .NUM_SLOTS (NSLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    blp_pool_checker #(
        .NUM_SLOTS (NSLOTS)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    // Offer one request word and hold it until accepted; a gap may follow
    task automatic offer_request(input logic op, input logic [FILE_W-1:0] fid,
                                 input logic [BLOCK_W-1:0] blk, input logic wm);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W-FILE_W-BLOCK_W-1){1'b0}}, wm, blk, fid};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
                                              : $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // result side: stall pattern in segments, one long hold-off
    initial begin : result_sink
        int seg_len;
        int mode;
        int cyc;
        bit held;
        cyc      = 0;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            seg_len = $urandom_range(1, 40);
            mode    = $urandom_range(0, 3);
            repeat (seg_len) begin
                case (mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_tready <= ($urandom_range(0, 7) != 0);
                    end
                endcase
                @(posedge aclk);
                cyc++;
            end
            if (!held && cyc >= 2500) begin
                // long hold-off while requests keep coming
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                held = 1'b1;
            end
        end
    end

    // request stimulus and verdict
    initial begin : request_source
        int pick;
        int r;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_ACCESS;
        burst_left = 4;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty flush, extreme tags, hits, dirty flush, full pool
        offer_request(OP_FLUSH, 8'h00, 24'h000000, 1'b0);
        offer_request(OP_ACCESS, 8'h00, 24'h000000, 1'b0);
        offer_request(OP_ACCESS, 8'hFF, 24'hFFFFFF, 1'b1);
        offer_request(OP_ACCESS, 8'h00, 24'h000000, 1'b1);
        offer_request(OP_ACCESS, 8'h00, 24'h000000, 1'b0);
        offer_request(OP_FLUSH, 8'hFF, 24'hFFFFFF, 1'b1);
        offer_request(OP_FLUSH, 8'h00, 24'h000000, 1'b0);
        for (int i = 2; i < NSLOTS; i++)
            offer_request(OP_ACCESS, FILE_W'(i * 17), BLOCK_W'((i << 20) ^ 24'h0F0F0F), 1'b1);
        // evict the clean count-one slot, then a dirty one
        offer_request(OP_ACCESS, 8'hA5, 24'h5A5A5A, 1'b1);
        offer_request(OP_ACCESS, 8'h5A, 24'hA5A5A5, 1'b1);
        offer_request(OP_ACCESS, 8'h00, 24'h000000, 1'b1);
        // every slot dirty: longest flush
        offer_request(OP_FLUSH, 8'h00, 24'h000000, 1'b0);

        // tag pool: extremes plus random tags, so hits and misses both occur
        pool_fid[0] = 8'h00;
        pool_blk[0] = 24'h000000;
        pool_fid[1] = 8'hFF;
        pool_blk[1] = 24'hFFFFFF;
        for (int i = 2; i < TAG_POOL; i++) begin
            pool_fid[i] = FILE_W'($urandom);
            pool_blk[i] = BLOCK_W'($urandom);
        end

        // random: mostly pool accesses with a skew, some flushes, some fresh tags
        for (int n = 0; n < RAND_N; n++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                offer_request(OP_FLUSH, FILE_W'($urandom), BLOCK_W'($urandom),
                              1'($urandom_range(0, 1)));
            end else if (r < 88) begin
                pick = $urandom_range(0, 1) ? $urandom_range(0, 9)
                                            : $urandom_range(0, TAG_POOL - 1);
                offer_request(OP_ACCESS, pool_fid[pick], pool_blk[pick],
                              1'($urandom_range(0, 1)));
            end else begin
                offer_request(OP_ACCESS, FILE_W'($urandom), BLOCK_W'($urandom),
                              1'($urandom_range(0, 1)));
            end
        end
        s_tvalid <= 1'b0;

        // drain, then let the block settle
        @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
        repeat (NSLOTS + 8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(12_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
